// ===== design/bcmc_pkg.sv =====
// Shared types and register map for the button calibration mode controller.
`timescale 1ns / 1ps
`default_nettype none

package bcmc_pkg;

    localparam int unsigned ADDR_BITS = 5;

    localparam logic [ADDR_BITS-1:0] ADDR_HOLD_TIME  = 5'd0;
    localparam logic [ADDR_BITS-1:0] ADDR_SAVE_DELAY = 5'd4;
    localparam logic [ADDR_BITS-1:0] ADDR_NOTICE     = 5'd8;
    localparam logic [ADDR_BITS-1:0] ADDR_STEP_SIZE  = 5'd12;
    localparam logic [ADDR_BITS-1:0] ADDR_START_CAL  = 5'd16;

    localparam logic [15:0] RST_HOLD_TIME  = 16'd2000;
    localparam logic [15:0] RST_SAVE_DELAY = 16'd8000;
    localparam logic [15:0] RST_NOTICE     = 16'd1500;
    localparam logic [15:0] RST_STEP_SIZE  = 16'd16;
    localparam logic [15:0] RST_START_CAL  = 16'd256;

    typedef struct packed {
        logic [15:0] hold_time_ms;
        logic [15:0] save_delay_ms;
        logic [15:0] notice_time_ms;
        logic [15:0] step_size;
        logic [15:0] start_calibration;
    } bcmc_cfg_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] calibration;
        logic        save_strobe;
        logic        notice_active;
    } bcmc_result_t;

endpackage

`default_nettype wire

// ===== design/bcmc_regs.sv =====
// APB configuration register file for the button calibration mode controller.
`timescale 1ns / 1ps
`default_nettype none

module bcmc_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bcmc_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output bcmc_pkg::bcmc_cfg_t                cfg,
    output logic                               load_cal,
    output logic      [15:0]                   load_value
);
    import bcmc_pkg::*;

    bcmc_cfg_t cfg_reg;
    bcmc_cfg_t cfg_next;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;
    assign load_cal = wr_en && (paddr == ADDR_START_CAL);
    assign load_value = pwdata[15:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr)
                ADDR_HOLD_TIME:  cfg_next.hold_time_ms      = pwdata[15:0];
                ADDR_SAVE_DELAY: cfg_next.save_delay_ms     = pwdata[15:0];
                ADDR_NOTICE:     cfg_next.notice_time_ms    = pwdata[15:0];
                ADDR_STEP_SIZE:  cfg_next.step_size         = pwdata[15:0];
                ADDR_START_CAL:  cfg_next.start_calibration = pwdata[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_HOLD_TIME:  prdata = {16'd0, cfg_reg.hold_time_ms};
            ADDR_SAVE_DELAY: prdata = {16'd0, cfg_reg.save_delay_ms};
            ADDR_NOTICE:     prdata = {16'd0, cfg_reg.notice_time_ms};
            ADDR_STEP_SIZE:  prdata = {16'd0, cfg_reg.step_size};
            ADDR_START_CAL:  prdata = {16'd0, cfg_reg.start_calibration};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_time_ms      <= RST_HOLD_TIME;
            cfg_reg.save_delay_ms     <= RST_SAVE_DELAY;
            cfg_reg.notice_time_ms    <= RST_NOTICE;
            cfg_reg.step_size         <= RST_STEP_SIZE;
            cfg_reg.start_calibration <= RST_START_CAL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/bcmc_core.sv =====
// Mode, calibration, save and notice state with its per-item update logic.
`timescale 1ns / 1ps
`default_nettype none

module bcmc_core #(
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire logic [31:0]           time_ms,
    input  wire logic                  up_pressed,
    input  wire logic                  down_pressed,
    input  wire bcmc_pkg::bcmc_cfg_t   cfg,
    input  wire logic                  load_cal,
    input  wire logic [15:0]           load_value,
    output bcmc_pkg::bcmc_result_t     result
);
    import bcmc_pkg::*;

    logic                 mode_reg, mode_next;
    logic [15:0]          cal_reg, cal_next;
    logic [TIME_BITS-1:0] hold_start_reg, hold_start_next;
    logic                 hold_fired_reg, hold_fired_next;
    logic                 prev_up_reg, prev_down_reg;
    logic                 pending_reg, pending_next;
    logic [TIME_BITS-1:0] last_save_reg, last_save_next;
    logic [TIME_BITS-1:0] deadline_reg, deadline_next;

    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] hold_elapsed;
    logic [TIME_BITS-1:0] save_elapsed;
    logic [16:0]          up_sum;
    logic [15:0]          cal_up;
    logic                 step_up, step_down, strobe;

    assign now          = TIME_BITS'(time_ms);
    assign hold_elapsed = now - hold_start_reg;
    assign save_elapsed = now - last_save_reg;

    always_comb
    begin
        hold_start_next = hold_start_reg;
        hold_fired_next = hold_fired_reg;
        mode_next       = mode_reg;
        if (up_pressed && down_pressed)
        begin
            if (hold_start_reg == '0)
            begin
                hold_start_next = now;
                hold_fired_next = 1'b0;
            end
            else if (!hold_fired_reg && (hold_elapsed >= TIME_BITS'(cfg.hold_time_ms)))
            begin
                hold_fired_next = 1'b1;
                mode_next       = ~mode_reg;
            end
        end
        else
        begin
            hold_start_next = '0;
            hold_fired_next = 1'b0;
        end

        step_up   = mode_next && prev_up_reg && !up_pressed && !down_pressed;
        step_down = mode_next && prev_down_reg && !down_pressed && !up_pressed;

        up_sum = {1'b0, cal_reg} + {1'b0, cfg.step_size};
        cal_up = cal_reg;
        if (step_up)
        begin
            cal_up = up_sum[16] ? 16'hFFFF : up_sum[15:0];
        end
        cal_next = cal_up;
        if (step_down)
        begin
            cal_next = (cal_up >= cfg.step_size) ? (cal_up - cfg.step_size) : 16'd0;
        end

        pending_next  = pending_reg;
        deadline_next = deadline_reg;
        if (step_up || step_down)
        begin
            pending_next  = 1'b1;
            deadline_next = '0;
        end

        strobe         = pending_next && (save_elapsed >= TIME_BITS'(cfg.save_delay_ms));
        last_save_next = last_save_reg;
        if (strobe)
        begin
            pending_next   = 1'b0;
            last_save_next = now;
            if (mode_next)
            begin
                deadline_next = now + TIME_BITS'(cfg.notice_time_ms);
            end
        end
        if ((deadline_next != '0) && (now >= deadline_next))
        begin
            deadline_next = '0;
        end

        result.mode          = mode_next;
        result.calibration   = cal_next;
        result.save_strobe   = strobe;
        result.notice_active = (deadline_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            cal_reg        <= RST_START_CAL;
            hold_start_reg <= '0;
            hold_fired_reg <= 1'b0;
            prev_up_reg    <= 1'b0;
            prev_down_reg  <= 1'b0;
            pending_reg    <= 1'b0;
            last_save_reg  <= '0;
            deadline_reg   <= '0;
        end
        else
        begin
            if (fire)
            begin
                mode_reg       <= mode_next;
                hold_start_reg <= hold_start_next;
                hold_fired_reg <= hold_fired_next;
                prev_up_reg    <= up_pressed;
                prev_down_reg  <= down_pressed;
                pending_reg    <= pending_next;
                last_save_reg  <= last_save_next;
                deadline_reg   <= deadline_next;
            end
            if (load_cal)
            begin
                cal_reg <= load_value;
            end
            else if (fire)
            begin
                cal_reg <= cal_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/button_calibration_mode_controller_top.sv =====
// Top level of the button calibration mode controller: item registers and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Channel    Handshake               Payload
// input      in_valid / in_ready     time_ms, up_pressed, down_pressed
// output     out_valid / out_ready   mode, calibration, save_strobe, notice_active
// config     APB psel/penable/pready paddr, pwdata, prdata
//
// An item is captured in the input register, updated by combinational logic, and
// its result lands in the output register when it fires, which raises out_valid.
// One item is accepted per cycle while the output register drains.
// Reset restores the config and core registers and clears both item valid flags.
// A stalled output holds the result and the input register until out_ready rises.

module button_calibration_mode_controller_top #(
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [31:0]                    time_ms,
    input  wire logic                           up_pressed,
    input  wire logic                           down_pressed,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                mode,
    output logic [15:0]                         calibration,
    output logic                                save_strobe,
    output logic                                notice_active,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bcmc_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);
    import bcmc_pkg::*;

    bcmc_cfg_t    cfg;
    bcmc_result_t result;
    bcmc_result_t res_reg;
    logic         load_cal;
    logic [15:0]  load_value;

    logic         ivalid_reg;
    logic [31:0]  time_reg;
    logic         up_reg;
    logic         down_reg;
    logic         ovalid_reg;
    logic         advance;
    logic         fire;

    assign advance  = !ovalid_reg || out_ready;
    assign fire     = ivalid_reg && advance;
    assign in_ready = !ivalid_reg || advance;

    bcmc_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg        (cfg),
        .load_cal   (load_cal),
        .load_value (load_value)
    );

    bcmc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .time_ms      (time_reg),
        .up_pressed   (up_reg),
        .down_pressed (down_reg),
        .cfg          (cfg),
        .load_cal     (load_cal),
        .load_value   (load_value),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                ivalid_reg <= in_valid;
            end
            if (fire)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            time_reg <= time_ms;
            up_reg   <= up_pressed;
            down_reg <= down_pressed;
        end
        if (fire)
        begin
            res_reg <= result;
        end
    end

    assign out_valid     = ovalid_reg;
    assign mode          = res_reg.mode;
    assign calibration   = res_reg.calibration;
    assign save_strobe   = res_reg.save_strobe;
    assign notice_active = res_reg.notice_active;

endmodule

`default_nettype wire
